@@ rtl/lkxd_pkg.sv @@
// shared types, register indexes and helpers for the keyed xor stream decryptor
package lkxd_pkg;

    // register reset values
    localparam logic [31:0] SEED_RESET   = 32'd1252;
    localparam logic [31:0] MULT_RESET   = 32'd17116;
    localparam logic [31:0] ADDEND_RESET = 32'd31995;

    // plaintext limits and allowed symbols
    localparam logic [7:0] MIN_PRINT  = 8'h20;
    localparam logic [7:0] CHR_SPACE  = 8'h20;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_NINE   = 8'h39;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_LBRACK = 8'h5B;
    localparam logic [7:0] CHR_RBRACK = 8'h5D;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_MULTIPLIER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_POSITIVE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ADDEND     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDEND_POSITIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE   = 3'd5;

    // input beat
    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       start_of_run;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [7:0] plain_byte;
        logic       byte_allowed;
        logic       run_failed;
    } out_beat_t;

    // configuration register set
    typedef struct packed {
        logic [31:0] key_seed;
        logic [31:0] key_multiplier;
        logic        multiplier_positive;
        logic [31:0] key_addend;
        logic        addend_positive;
        logic        check_enable;
    } cfg_regs_t;

    // space, digits, slash, colon and square brackets
    function automatic logic is_allowed(input logic [7:0] b);
        logic digit;
        digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
        return digit || (b == CHR_SPACE) || (b == CHR_SLASH) || (b == CHR_COLON)
            || (b == CHR_LBRACK) || (b == CHR_RBRACK);
    endfunction

endpackage

@@ rtl/lcg_keyed_xor_stream_decrypt.sv @@
// top level of the keyed xor stream decryptor with input and result registers
// One ciphertext byte enters per clock; its plaintext beat waits in the input register, then
// the key feedback (add, 32x32 multiply keeping the low word, signed add) and the set check
// run in one combinational pass into the result register. The key loop closes through the
// key register alone, so the sustained rate is one byte per clock whenever the consumer
// takes results. The user must write configuration only while no bytes are in flight; the
// block itself does not enforce it. A new seed takes effect on the next beat marked
// start_of_run.
module lcg_keyed_xor_stream_decrypt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkxd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lkxd_pkg::in_beat_t                in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lkxd_pkg::out_beat_t               out_data
);
    import lkxd_pkg::*;

    cfg_regs_t cfg;
    in_beat_t  in_reg;
    logic      in_valid_reg;
    out_beat_t out_reg;
    logic      out_valid_reg;
    out_beat_t result;
    logic      advance;

    // configuration always takes a write
    assign cfg_ready = 1'b1;

    lkxd_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // handshake between input register and result register
    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;

    lkxd_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .beat_in  (in_reg),
        .cfg      (cfg),
        .beat_out (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // a byte that moves on always lands in the result register
    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register empty after a byte moved on");

    // a held input beat is not lost or altered while the result side stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("input register changed while stalled");

    // start of run with checking off reports no failure
    a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_reg.start_of_run && !cfg.check_enable |=> !out_reg.run_failed)
        else $error("run failure reported at a run start with checking off");

    // an allowed byte is never clamped
    a_allowed_unclamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.byte_allowed |-> out_reg.plain_byte >= MIN_PRINT)
        else $error("allowed byte below the printable limit");

endmodule

@@ rtl/lkxd_cfg.sv @@
// configuration register file for the keyed xor stream decryptor
module lkxd_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [lkxd_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [31:0]                        wr_data,
    output lkxd_pkg::cfg_regs_t                cfg
);
    import lkxd_pkg::*;

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // decode the write beat, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_KEY_SEED:        cfg_next.key_seed            = wr_data;
                CFG_KEY_MULTIPLIER:  cfg_next.key_multiplier      = wr_data;
                CFG_MULT_POSITIVE:   cfg_next.multiplier_positive = wr_data[0];
                CFG_KEY_ADDEND:      cfg_next.key_addend          = wr_data;
                CFG_ADDEND_POSITIVE: cfg_next.addend_positive     = wr_data[0];
                CFG_CHECK_ENABLE:    cfg_next.check_enable        = wr_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // register set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_seed            <= SEED_RESET;
            cfg_reg.key_multiplier      <= MULT_RESET;
            cfg_reg.multiplier_positive <= 1'b1;
            cfg_reg.key_addend          <= ADDEND_RESET;
            cfg_reg.addend_positive     <= 1'b1;
            cfg_reg.check_enable        <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/lkxd_core.sv @@
// key register, feedback update and plaintext check for one byte per cycle while advance is high
module lkxd_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  lkxd_pkg::in_beat_t   beat_in,
    input  lkxd_pkg::cfg_regs_t  cfg,
    output lkxd_pkg::out_beat_t  beat_out
);
    import lkxd_pkg::*;

    logic [31:0] key_reg;
    logic [31:0] key_next;
    logic        failed_reg;
    logic        failed_next;

    logic [31:0] key_cur;
    logic        failed_cur;
    logic [7:0]  raw;
    logic        ok;
    logic [31:0] sum;
    logic [31:0] prod;
    logic [31:0] prod_term;
    logic [31:0] addend_term;

    // start of run reloads the seed and clears the failure flag
    assign key_cur    = beat_in.start_of_run ? cfg.key_seed : key_reg;
    assign failed_cur = beat_in.start_of_run ? 1'b0 : failed_reg;

    // keystream byte and set check
    assign raw         = key_cur[15:8] ^ beat_in.cipher_byte;
    assign ok          = is_allowed(raw);
    assign failed_next = failed_cur | (cfg.check_enable & ~ok);

    // ciphertext feedback: key = +/-mult*(key+c) +/- addend, low 32 bits
    assign sum         = key_cur + {24'd0, beat_in.cipher_byte};
    assign prod        = sum * cfg.key_multiplier;
    assign prod_term   = cfg.multiplier_positive ? prod : (32'd0 - prod);
    assign addend_term = cfg.addend_positive ? cfg.key_addend : (32'd0 - cfg.key_addend);
    assign key_next    = prod_term + addend_term;

    // result beat
    always_comb
    begin
        beat_out.plain_byte   = (raw < MIN_PRINT) ? MIN_PRINT : raw;
        beat_out.byte_allowed = ok;
        beat_out.run_failed   = failed_next;
    end

    // stream state, moves only when a byte goes through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= SEED_RESET;
            failed_reg <= 1'b0;
        end
        else if (advance)
        begin
            key_reg    <= key_next;
            failed_reg <= failed_next;
        end
    end

endmodule

@@ tb/lcg_keyed_xor_stream_decrypt_test.sv @@
// self-checking testbench for the keyed xor stream decryptor with its own key predictor
module lcg_keyed_xor_stream_decrypt_test;

    import lkxd_pkg::*;

    // indexes that no register answers to
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_REPORTS  = 40;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 100;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_beat_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_beat_t            out_data;

    // predictor state
    cfg_regs_t   exp_cfg;
    logic [31:0] exp_key;
    logic        exp_failed;
    out_beat_t   plain_expected[$];

    // traffic shaping
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;

    // run statistics
    int errors         = 0;
    int bytes_sent     = 0;
    int runs_started   = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int input_stalls   = 0;

    lcg_keyed_xor_stream_decrypt dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // predictor back to its reset state
    task automatic reset_predictor();
        exp_cfg.key_seed            = SEED_RESET;
        exp_cfg.key_multiplier      = MULT_RESET;
        exp_cfg.multiplier_positive = 1'b1;
        exp_cfg.key_addend          = ADDEND_RESET;
        exp_cfg.addend_positive     = 1'b1;
        exp_cfg.check_enable        = 1'b1;
        exp_key                     = SEED_RESET;
        exp_failed                  = 1'b0;
    endtask

    // decrypt one accepted beat, queue its plaintext and step the key
    task automatic predict_plain(input in_beat_t beat);
        out_beat_t   res;
        logic [7:0]  raw;
        logic        ok;
        logic [31:0] sum;
        logic [31:0] prod;
        if (beat.start_of_run)
        begin
            exp_key    = exp_cfg.key_seed;
            exp_failed = 1'b0;
        end
        raw = exp_key[15:8] ^ beat.cipher_byte;
        case (raw)
            CHR_SPACE, CHR_SLASH, CHR_COLON, CHR_LBRACK, CHR_RBRACK: ok = 1'b1;
            default: ok = (raw >= CHR_ZERO) && (raw <= CHR_NINE);
        endcase
        if (exp_cfg.check_enable && !ok)
            exp_failed = 1'b1;
        res.plain_byte   = (raw < MIN_PRINT) ? MIN_PRINT : raw;
        res.byte_allowed = ok;
        res.run_failed   = exp_failed;
        // ciphertext feedback into the key
        sum  = exp_key + {24'd0, beat.cipher_byte};
        prod = sum * exp_cfg.key_multiplier;
        case ({exp_cfg.multiplier_positive, exp_cfg.addend_positive})
            2'b11:   exp_key = prod + exp_cfg.key_addend;
            2'b10:   exp_key = prod - exp_cfg.key_addend;
            2'b01:   exp_key = exp_cfg.key_addend - prod;
            default: exp_key = 32'd0 - exp_cfg.key_addend - prod;
        endcase
        plain_expected.insert(plain_expected.size(), res);
    endtask

    // compare one result beat with the oldest expectation
    task automatic compare_plain(input out_beat_t got);
        out_beat_t want;
        results_seen++;
        if (plain_expected.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t unexpected result beat: expected none, got %h", $time, got);
            return;
        end
        want = plain_expected.pop_front();
        if (got.plain_byte !== want.plain_byte)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t plain_byte mismatch: expected %h, got %h",
                         $time, want.plain_byte, got.plain_byte);
        end
        if (got.byte_allowed !== want.byte_allowed)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t byte_allowed mismatch: expected %b, got %b",
                         $time, want.byte_allowed, got.byte_allowed);
        end
        if (got.run_failed !== want.run_failed)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t run_failed mismatch: expected %b, got %b",
                         $time, want.run_failed, got.run_failed);
        end
    endtask

    // result side: check beats, stall at random or hold off on request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
            input_stalls++;
        if (rst_n && out_valid && out_ready)
            compare_plain(out_data);
        if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one ciphertext beat, predict on acceptance, then maybe idle
    task automatic send_byte(input logic [7:0] cipher, input logic start);
        in_beat_t beat;
        beat.cipher_byte  = cipher;
        beat.start_of_run = start;
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (!in_ready);
        predict_plain(beat);
        bytes_sent++;
        if (start)
            runs_started++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // send the ciphertext that decrypts to a chosen plaintext
    task automatic send_plain(input logic [7:0] target, input logic start);
        logic [7:0] key_byte;
        key_byte = start ? exp_cfg.key_seed[15:8] : exp_key[15:8];
        send_byte(target ^ key_byte, start);
    endtask

    // register write, only while nothing is in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_KEY_SEED:        exp_cfg.key_seed            = data;
            CFG_KEY_MULTIPLIER:  exp_cfg.key_multiplier      = data;
            CFG_MULT_POSITIVE:   exp_cfg.multiplier_positive = data[0];
            CFG_KEY_ADDEND:      exp_cfg.key_addend          = data;
            CFG_ADDEND_POSITIVE: exp_cfg.addend_positive     = data[0];
            CFG_CHECK_ENABLE:    exp_cfg.check_enable        = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid and let every expected beat come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (plain_expected.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_allowed();
        int sel;
        sel = $urandom_range(14);
        case (sel)
            10:      return CHR_SPACE;
            11:      return CHR_SLASH;
            12:      return CHR_COLON;
            13:      return CHR_LBRACK;
            14:      return CHR_RBRACK;
            default: return CHR_ZERO + sel[7:0];
        endcase
    endfunction

    // new key setting; the sign pair walks through all four combinations
    task automatic randomise_config(input int k);
        logic [31:0] r;
        write_reg(CFG_KEY_SEED, pick_word());
        write_reg(CFG_KEY_MULTIPLIER, pick_word());
        write_reg(CFG_KEY_ADDEND, pick_word());
        r    = $urandom;
        r[0] = k[0];
        write_reg(CFG_MULT_POSITIVE, r);
        r    = $urandom;
        r[0] = k[1];
        write_reg(CFG_ADDEND_POSITIVE, r);
        r    = $urandom;
        r[0] = ($urandom_range(3) != 0);
        write_reg(CFG_CHECK_ENABLE, r);
        if ($urandom_range(1))
            write_reg(CFG_UNUSED_B, $urandom);
        settings_used++;
    endtask

    // mostly well-formed runs of allowed plaintext, some bad bytes and raw noise
    task automatic send_runs(input int n);
        int left;
        int len;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
                left--;
            end
            else
            begin
                len = $urandom_range(16, 1);
                for (int i = 0; i < len && left > 0; i++)
                begin
                    if ($urandom_range(9) == 0)
                        send_plain(8'($urandom_range(255)), i == 0);
                    else
                        send_plain(pick_allowed(), i == 0);
                    left--;
                end
            end
        end
    endtask

    // reset key, field extremes and every edge of the allowed set
    task automatic test_plaintext_edges();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_plain(8'h00, 1'b1);
        send_plain(8'h1F, 1'b0);
        send_plain(CHR_SPACE, 1'b0);
        send_plain(CHR_SLASH, 1'b1);
        send_plain(CHR_ZERO, 1'b0);
        send_plain(CHR_NINE, 1'b0);
        send_plain(CHR_COLON, 1'b0);
        send_plain(CHR_LBRACK, 1'b0);
        send_plain(CHR_RBRACK, 1'b0);
        send_plain(8'h2E, 1'b0);
        send_plain(8'h3B, 1'b0);
        send_plain(8'h5C, 1'b0);
        send_plain(8'hFF, 1'b0);
        wait_idle();
    endtask

    // checking off, seed change mid-run, both signs negative, unused indexes
    task automatic test_register_cases();
        // upper bits ignored: this turns checking off
        write_reg(CFG_CHECK_ENABLE, 32'hFFFF_FFFE);
        send_plain(8'h5C, 1'b1);
        wait_idle();
        write_reg(CFG_CHECK_ENABLE, 32'h0000_0001);
        send_plain(8'h41, 1'b0);
        wait_idle();
        // flag stays set while checking is off
        write_reg(CFG_CHECK_ENABLE, 32'h0000_0000);
        send_plain(CHR_ZERO, 1'b0);
        wait_idle();
        write_reg(CFG_CHECK_ENABLE, 32'h8000_0001);
        // new seed only lands at the next start of run
        write_reg(CFG_KEY_SEED, 32'hFFFF_FFFF);
        send_plain(CHR_NINE, 1'b0);
        send_plain(CHR_SPACE, 1'b1);
        wait_idle();
        write_reg(CFG_MULT_POSITIVE, 32'h0000_0000);
        write_reg(CFG_ADDEND_POSITIVE, 32'hFFFF_FFFE);
        write_reg(CFG_KEY_MULTIPLIER, 32'hFFFF_FFFF);
        write_reg(CFG_KEY_ADDEND, 32'hFFFF_FFFF);
        settings_used++;
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_idle();
        write_reg(CFG_UNUSED_A, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_B, 32'h0000_0000);
        send_byte(8'h5A, 1'b0);
        wait_idle();
        write_reg(CFG_KEY_SEED, 32'h0000_0000);
        write_reg(CFG_KEY_MULTIPLIER, 32'h0000_0000);
        write_reg(CFG_KEY_ADDEND, 32'h0000_0000);
        settings_used++;
        send_plain(CHR_COLON, 1'b1);
        send_byte(8'hA5, 1'b0);
        wait_idle();
    endtask

    // random traffic under one idle and stall mix, two key settings
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int s = 0; s < 2; s++)
        begin
            randomise_config(settings_used);
            send_runs(RANDOM_BYTES);
            wait_idle();
        end
    endtask

    // hold the result side off while the sender keeps offering beats
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 40; i++)
            send_plain(pick_allowed(), i == 0);
        wait_idle();
    endtask

    // test sequence
    initial
    begin
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plaintext_edges();
        test_register_cases();
        test_random_traffic(0, 0);
        test_random_traffic(79, 0);
        test_random_traffic(0, 79);
        test_random_traffic(11, 11);
        test_backpressure();

        // drain whatever is left, within a limit
        recv_stall_pct = 0;
        in_valid <= 1'b0;
        for (int i = 0; i < DRAIN_LIMIT && plain_expected.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (plain_expected.size() != 0)
        begin
            errors++;
            $display("%0t %0d expected beats never arrived: expected 0, got %0d",
                     $time, plain_expected.size(), plain_expected.size());
        end

        $display("decrypted %0d bytes in %0d runs over %0d key settings, %0d beats checked",
                 bytes_sent, runs_started, settings_used, results_seen);
        $display("all sign pairs, checking on and off, idle and stall mixes, %0d input stalls",
                 input_stalls);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
